[design/htfd_pkg.sv]
package htfd_pkg;

	// crc-8 of the measurement words
	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'hFF;

	// conversion constants, hundredths of a unit over a 16-bit full scale
	localparam int unsigned TEMP_SCALE  = 17500;
	localparam int unsigned HUMI_SCALE  = 10000;
	localparam int unsigned TEMP_OFFSET = 4500;
	localparam int unsigned FULL_SCALE  = 65535;
	localparam int unsigned HUMI_MAX    = 10000;

	// product widths: 17500 * 65535 < 2^31, 10000 * 65535 < 2^30
	localparam int unsigned PROD_W = 31;

	// position of the next byte within a frame
	typedef enum logic [2:0] {
		POS_T_MSB = 3'd0,
		POS_T_LSB = 3'd1,
		POS_T_CRC = 3'd2,
		POS_H_MSB = 3'd3,
		POS_H_LSB = 3'd4,
		POS_H_CRC = 3'd5
	} pos_t;

	// one complete frame handed from front to back
	typedef struct packed {
		logic [15:0] temp_raw;
		logic [15:0] humi_raw;
		logic        temp_ok;
		logic        humi_ok;
	} frame_t;

	// bytewise crc update, msb first, no final xor
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

	// floor(x / 65535) for x below 65535 * 32768
	// x = q0 * 65535 + (q0 + lo), and q0 + lo stays below twice the divisor
	function automatic logic [14:0] div_full_scale(input logic [PROD_W-1:0] x);
		logic [14:0] q0;
		logic [16:0] r;
		q0 = x[PROD_W-1:16];
		r  = {1'b0, x[15:0]} + {2'b00, q0};
		if (r >= 17'(FULL_SCALE)) begin
			return q0 + 15'd1;
		end
		return q0;
	endfunction

endpackage

[design/htfd_front.sv]
module htfd_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  logic [7:0]      rx_byte,
	input  logic            sync,
	input  logic            q_full,
	output logic            q_push,
	output htfd_pkg::frame_t q_data
);
	import htfd_pkg::*;

	pos_t        pos_q, pos_d, eff_pos;
	logic [7:0]  crc_q, crc_d, crc_in, crc_upd;
	logic [15:0] temp_raw_q, humi_raw_q;
	logic        temp_ok_q;
	logic        accept;
	logic        t_msb_we, t_lsb_we, t_crc_we, h_msb_we, h_lsb_we;
	logic        byte_crc_match;

	// a byte is taken only while the frame queue has room
	assign full   = q_full;
	assign accept = push && !full;

	// sync restarts the frame at its first byte with a fresh crc
	assign eff_pos        = sync ? POS_T_MSB : pos_q;
	assign crc_in         = sync ? CRC_INIT : crc_q;
	assign crc_upd        = crc8_update(crc_in, rx_byte);
	assign byte_crc_match = (crc_in == rx_byte);

	// next byte position
	always_comb begin
		pos_d = pos_q;
		if (accept) begin
			case (eff_pos)
				POS_T_MSB: pos_d = POS_T_LSB;
				POS_T_LSB: pos_d = POS_T_CRC;
				POS_T_CRC: pos_d = POS_H_MSB;
				POS_H_MSB: pos_d = POS_H_LSB;
				POS_H_LSB: pos_d = POS_H_CRC;
				POS_H_CRC: pos_d = POS_T_MSB;
				default:   pos_d = POS_T_LSB;
			endcase
		end
	end

	// per-position actions
	always_comb begin
		crc_d    = crc_q;
		t_msb_we = 1'b0;
		t_lsb_we = 1'b0;
		t_crc_we = 1'b0;
		h_msb_we = 1'b0;
		h_lsb_we = 1'b0;
		q_push   = 1'b0;
		if (accept) begin
			case (eff_pos)
				POS_T_MSB: begin
					t_msb_we = 1'b1;
					crc_d    = crc_upd;
				end
				POS_T_LSB: begin
					t_lsb_we = 1'b1;
					crc_d    = crc_upd;
				end
				POS_T_CRC: begin
					t_crc_we = 1'b1;
					crc_d    = CRC_INIT;
				end
				POS_H_MSB: begin
					h_msb_we = 1'b1;
					crc_d    = crc_upd;
				end
				POS_H_LSB: begin
					h_lsb_we = 1'b1;
					crc_d    = crc_upd;
				end
				POS_H_CRC: begin
					q_push = 1'b1;
					crc_d  = CRC_INIT;
				end
				default: begin
					t_msb_we = 1'b1;
					crc_d    = crc_upd;
				end
			endcase
		end
	end

	// completed frame for the queue
	assign q_data.temp_raw = temp_raw_q;
	assign q_data.humi_raw = humi_raw_q;
	assign q_data.temp_ok  = temp_ok_q;
	assign q_data.humi_ok  = byte_crc_match;

	// position, crc and raw word registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= POS_T_MSB;
			crc_q      <= CRC_INIT;
			temp_raw_q <= '0;
			humi_raw_q <= '0;
			temp_ok_q  <= 1'b0;
		end else begin
			pos_q <= pos_d;
			crc_q <= crc_d;
			if (t_msb_we) begin
				temp_raw_q[15:8] <= rx_byte;
			end
			if (t_lsb_we) begin
				temp_raw_q[7:0] <= rx_byte;
			end
			if (t_crc_we) begin
				temp_ok_q <= byte_crc_match;
			end
			if (h_msb_we) begin
				humi_raw_q[15:8] <= rx_byte;
			end
			if (h_lsb_we) begin
				humi_raw_q[7:0] <= rx_byte;
			end
		end
	end

endmodule

[design/htfd_queue.sv]
module htfd_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  htfd_pkg::frame_t wr_data,
	output logic             full,
	input  logic             rd_en,
	output htfd_pkg::frame_t rd_data,
	output logic             empty
);
	import htfd_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	frame_t             mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_wr, do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// frame storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[design/htfd_back.sv]
module htfd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  htfd_pkg::frame_t   q_data,
	output logic               q_pop,
	output logic               empty,
	input  logic               pop,
	output logic signed [14:0] temperature_centi,
	output logic [13:0]        humidity_centi,
	output logic               temp_crc_ok,
	output logic               humi_crc_ok,
	output logic               frame_valid
);
	import htfd_pkg::*;

	logic              v_s1, v_s2;
	logic [PROD_W-1:0] t_prod_s1, h_prod_s1;
	logic              t_ok_s1, h_ok_s1;
	logic [14:0]       t_quot, h_quot;
	logic [15:0]       t_centi;
	logic              ld_s1, ld_s2;

	// stages move on whenever the stage ahead is free or drains
	assign ld_s2 = !v_s2 || pop;
	assign ld_s1 = !v_s1 || ld_s2;
	assign q_pop = ld_s1 && !q_empty;

	// stage 2 arithmetic: reciprocal divide and offset
	assign t_quot  = div_full_scale(t_prod_s1);
	assign h_quot  = div_full_scale(h_prod_s1);
	assign t_centi = {1'b0, t_quot} - 16'(TEMP_OFFSET);

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (ld_s1) begin
				v_s1 <= !q_empty;
			end
			if (ld_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// stage 1: scale both raw words
	always_ff @(posedge clk) begin
		if (ld_s1) begin
			t_prod_s1 <= PROD_W'(q_data.temp_raw) * PROD_W'(TEMP_SCALE);
			h_prod_s1 <= PROD_W'(q_data.humi_raw) * PROD_W'(HUMI_SCALE);
			t_ok_s1   <= q_data.temp_ok;
			h_ok_s1   <= q_data.humi_ok;
		end
	end

	// stage 2: result register, head of the result queue
	always_ff @(posedge clk) begin
		if (ld_s2) begin
			temperature_centi <= $signed(t_centi[14:0]);
			humidity_centi    <= h_quot[13:0];
			temp_crc_ok       <= t_ok_s1;
			humi_crc_ok       <= h_ok_s1;
			frame_valid       <= t_ok_s1 && h_ok_s1;
		end
	end

	assign empty = !v_s2;

endmodule

[design/humidity_temp_frame_decoder.sv]
// Measurement frame decoder for a humidity/temperature sensor.
// Input queue side: one received byte per beat on rx_byte, taken when push is
// high and full is low. Six bytes make a frame: temperature word (msb, lsb),
// its crc-8, humidity word (msb, lsb), its crc-8. sync on a beat makes that
// byte the first of a new frame and drops any partial frame.
// Result queue side: while empty is low the oldest result is on the result
// ports; it leaves on a beat with pop high. One result per frame, carrying
// both converted values and the crc flags, even when a check fails.
// Throughput: one byte per cycle while full is low. A finished frame passes the
// frame queue, the scaling multiply register and, after the reciprocal divide,
// the result register before its result is on the ports.
// A stalled receiver holds the result; up to QUEUE_DEPTH + 2 finished frames
// wait inside before full rises, and full follows the frame queue, so while
// it is high no byte is taken, even in the middle of a frame.
// Reset clears byte position, crc and all queues; no result is pending.
module humidity_temp_frame_decoder #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         rx_byte,
	input  logic               sync,
	output logic               empty,
	input  logic               pop,
	output logic signed [14:0] temperature_centi,
	output logic [13:0]        humidity_centi,
	output logic               temp_crc_ok,
	output logic               humi_crc_ok,
	output logic               frame_valid
);
	import htfd_pkg::*;

	logic   f_push, q_full, q_empty, q_pop;
	frame_t f_data, q_data;

	// byte intake, crc and frame assembly
	htfd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.rx_byte (rx_byte),
		.sync    (sync),
		.q_full  (q_full),
		.q_push  (f_push),
		.q_data  (f_data)
	);

	// frame queue between front and back
	htfd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (f_push),
		.wr_data (f_data),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (q_data),
		.empty   (q_empty)
	);

	// unit conversion and result register
	htfd_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.q_empty           (q_empty),
		.q_data            (q_data),
		.q_pop             (q_pop),
		.empty             (empty),
		.pop               (pop),
		.temperature_centi (temperature_centi),
		.humidity_centi    (humidity_centi),
		.temp_crc_ok       (temp_crc_ok),
		.humi_crc_ok       (humi_crc_ok),
		.frame_valid       (frame_valid)
	);

	// front never pushes a frame into a full queue
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		f_push |-> !q_full)
		else $error("frame pushed into full queue");

	// queue cannot be full and empty at once
	a_queue_level: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_full && q_empty))
		else $error("frame queue full and empty together");

	// a frame that leaves the queue passes stage 1 into the result register, so a result is then waiting
	a_pop_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> ##2 !empty)
		else $error("popped frame lost in back pipeline");

	// converted humidity stays in range and the verdict matches both flags
	a_result_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (humidity_centi <= 14'(HUMI_MAX))
			&& (frame_valid == (temp_crc_ok && humi_crc_ok)))
		else $error("result out of range or inconsistent verdict");

endmodule
